// ===== rtl/lbf_pkg.sv =====
`timescale 1ns / 1ps

package lbf_pkg;

   localparam int DEPTH  = 4096;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int BC_W   = 6;
   localparam int IDX_W  = $clog2(DATA_W);

   localparam logic [BC_W-1:0] MAX_BITS = BC_W'(DATA_W);
   localparam logic [3:0]      RD_EMPTY = 4'd8;

   typedef enum logic [2:0] {
      CMD_ADD_BITS = 3'd0,
      CMD_ADD_BYTE = 3'd1,
      CMD_PAD      = 3'd2,
      CMD_GET_BITS = 3'd3,
      CMD_GET_BYTE = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_OVERFLOW = 2'd1,
      STS_UNDERRUN = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_BUSY,
      S_HOLD
   } state_type;

   typedef struct packed {
      logic              start_wr;
      logic              start_rd;
      logic [2:0]        cmd;
      logic [DATA_W-1:0] value;
      logic [BC_W-1:0]   count;
   } ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic overflow;
   } wsts_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic underrun;
   } rsts_type;

   function automatic logic is_write_cmd(logic [2:0] c);
      return c inside {CMD_ADD_BITS, CMD_ADD_BYTE, CMD_PAD};
   endfunction

   function automatic logic is_read_cmd(logic [2:0] c);
      return c inside {CMD_GET_BITS, CMD_GET_BYTE};
   endfunction

endpackage

// ===== rtl/lbf_if.sv =====
`timescale 1ns / 1ps

interface lbf_req_if;
   logic                       valid;
   logic                       ready;
   logic [2:0]                 cmd;
   logic [lbf_pkg::DATA_W-1:0] value;
   logic [lbf_pkg::BC_W-1:0]   bit_count;

   modport source (output valid, cmd, value, bit_count, input ready);
   modport sink   (input valid, cmd, value, bit_count, output ready);
endinterface

interface lbf_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [lbf_pkg::DATA_W-1:0] read_value;
   logic [1:0]                 status;
   logic [lbf_pkg::CNT_W-1:0]  bytes_stored;

   modport source (output valid, read_value, status, bytes_stored, input ready);
   modport sink   (input valid, read_value, status, bytes_stored, output ready);
endinterface

// ===== rtl/lbf_ram.sv =====
`timescale 1ns / 1ps

module lbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/lbf_packer.sv =====
`timescale 1ns / 1ps

module lbf_packer (
   input  logic                         clock,
   input  logic                         reset,
   input  lbf_pkg::ctl_type             ctl,
   output lbf_pkg::wsts_type            sts,
   output logic [lbf_pkg::CNT_W-1:0]    wr_count,
   output logic                         ram_we,
   output logic [lbf_pkg::ADDR_W-1:0]   ram_waddr,
   output logic [7:0]                   ram_wdata
);
   import lbf_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              ovf_ff, ovf_in;
   logic [2:0]        cmd_ff, cmd_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [BC_W-1:0]   left_ff, left_in;
   logic [CNT_W-1:0]  wr_count_ff, wr_count_in;
   logic [7:0]        partial_ff, partial_in;
   logic [2:0]        fill_ff, fill_in;

   logic              commit;
   logic [7:0]        commit_byte;
   logic [7:0]        part;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         done_ff     <= 1'b0;
         ovf_ff      <= 1'b0;
         wr_count_ff <= '0;
         partial_ff  <= '0;
         fill_ff     <= '0;
      end else begin
         busy_ff     <= busy_in;
         done_ff     <= done_in;
         ovf_ff      <= ovf_in;
         wr_count_ff <= wr_count_in;
         partial_ff  <= partial_in;
         fill_ff     <= fill_in;
      end
      cmd_ff  <= cmd_in;
      val_ff  <= val_in;
      left_ff <= left_in;
   end

   always_comb begin
      busy_in     = busy_ff;
      done_in     = 1'b0;
      ovf_in      = ovf_ff;
      cmd_in      = cmd_ff;
      val_in      = val_ff;
      left_in     = left_ff;
      wr_count_in = wr_count_ff;
      partial_in  = partial_ff;
      fill_in     = fill_ff;
      commit      = 1'b0;
      commit_byte = partial_ff;
      part        = partial_ff;
      ram_we      = 1'b0;
      ram_waddr   = wr_count_ff[ADDR_W-1:0];
      ram_wdata   = '0;

      if (ctl.start_wr) begin
         busy_in = 1'b1;
         ovf_in  = 1'b0;
         cmd_in  = ctl.cmd;
         val_in  = ctl.value;
         left_in = ctl.count;
      end else if (busy_ff) begin
         case (cmd_ff)
            CMD_ADD_BITS: begin
               if (left_ff == '0) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end else begin
                  // bits above fill are always zero, so set the bit in place
                  part[fill_ff] = val_ff[0];
                  partial_in    = part;
                  fill_in       = fill_ff + 3'd1;
                  val_in        = val_ff >> 1;
                  left_in       = left_ff - BC_W'(1);
                  commit        = (fill_ff == 3'd7);
                  commit_byte   = part;
               end
            end
            CMD_ADD_BYTE: begin
               commit = 1'b1;
               if (fill_ff == '0) begin
                  commit_byte = val_ff[7:0];
                  busy_in     = 1'b0;
                  done_in     = 1'b1;
               end
            end
            CMD_PAD: begin
               commit  = (fill_ff != '0);
               busy_in = 1'b0;
               done_in = 1'b1;
            end
            default: begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         endcase

         if (commit) begin
            partial_in = '0;
            fill_in    = '0;
            if (wr_count_ff < CNT_W'(DEPTH)) begin
               ram_we      = 1'b1;
               ram_wdata   = commit_byte;
               wr_count_in = wr_count_ff + CNT_W'(1);
            end else begin
               ovf_in = 1'b1;
            end
         end
      end
   end

   assign sts.busy     = busy_ff;
   assign sts.done     = done_ff;
   assign sts.overflow = ovf_ff;
   assign wr_count     = wr_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      wr_count_ff <= CNT_W'(DEPTH))
      else $error("committed byte count beyond store depth");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (wr_count_ff < CNT_W'(DEPTH)) && (wr_count_in == wr_count_ff + CNT_W'(1)))
      else $error("store write without room or without count advance");

endmodule

// ===== rtl/lbf_unpacker.sv =====
`timescale 1ns / 1ps

module lbf_unpacker (
   input  logic                          clock,
   input  logic                          reset,
   input  lbf_pkg::ctl_type              ctl,
   input  logic [lbf_pkg::CNT_W-1:0]     wr_count,
   output logic                          ram_re,
   output logic [lbf_pkg::ADDR_W-1:0]    ram_raddr,
   input  logic [7:0]                    ram_rdata,
   output lbf_pkg::rsts_type             sts,
   output logic [lbf_pkg::DATA_W-1:0]    result
);
   import lbf_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              und_ff, und_in;
   logic              wait_ff, wait_in;
   logic [2:0]        cmd_ff, cmd_in;
   logic [BC_W-1:0]   left_ff, left_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [DATA_W-1:0] res_ff, res_in;
   logic [CNT_W-1:0]  rd_pos_ff, rd_pos_in;
   logic [3:0]        rd_bit_ff, rd_bit_in;
   logic [7:0]        rd_byte_ff, rd_byte_in;

   logic              fetch;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         done_ff    <= 1'b0;
         und_ff     <= 1'b0;
         wait_ff    <= 1'b0;
         rd_pos_ff  <= '0;
         rd_bit_ff  <= RD_EMPTY;
         rd_byte_ff <= '0;
      end else begin
         busy_ff    <= busy_in;
         done_ff    <= done_in;
         und_ff     <= und_in;
         wait_ff    <= wait_in;
         rd_pos_ff  <= rd_pos_in;
         rd_bit_ff  <= rd_bit_in;
         rd_byte_ff <= rd_byte_in;
      end
      cmd_ff  <= cmd_in;
      left_ff <= left_in;
      idx_ff  <= idx_in;
      res_ff  <= res_in;
   end

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      und_in     = und_ff;
      wait_in    = wait_ff;
      cmd_in     = cmd_ff;
      left_in    = left_ff;
      idx_in     = idx_ff;
      res_in     = res_ff;
      rd_pos_in  = rd_pos_ff;
      rd_bit_in  = rd_bit_ff;
      rd_byte_in = rd_byte_ff;
      fetch      = 1'b0;
      ram_re     = 1'b0;
      ram_raddr  = rd_pos_ff[ADDR_W-1:0];

      if (ctl.start_rd) begin
         busy_in = 1'b1;
         und_in  = 1'b0;
         cmd_in  = ctl.cmd;
         left_in = ctl.count;
         idx_in  = '0;
         res_in  = '0;
      end else if (busy_ff) begin
         if (wait_ff) begin
            // registered read data lands in the cycle after the address
            rd_byte_in = ram_rdata;
            rd_pos_in  = rd_pos_ff + CNT_W'(1);
            wait_in    = 1'b0;
         end else begin
            case (cmd_ff)
               CMD_GET_BITS: begin
                  if (left_ff == '0) begin
                     busy_in = 1'b0;
                     done_in = 1'b1;
                  end else if (rd_bit_ff == RD_EMPTY) begin
                     fetch = 1'b1;
                  end else begin
                     res_in[idx_ff] = rd_byte_ff[rd_bit_ff[2:0]];
                     rd_bit_in      = rd_bit_ff + 4'd1;
                     idx_in         = idx_ff + IDX_W'(1);
                     left_in        = left_ff - BC_W'(1);
                  end
               end
               CMD_GET_BYTE: begin
                  if (rd_bit_ff != '0) begin
                     fetch = 1'b1;
                  end else begin
                     res_in    = DATA_W'(rd_byte_ff);
                     rd_bit_in = RD_EMPTY;
                     busy_in   = 1'b0;
                     done_in   = 1'b1;
                  end
               end
               default: begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            endcase
         end

         if (fetch) begin
            rd_bit_in = '0;
            if (rd_pos_ff < wr_count) begin
               ram_re  = 1'b1;
               wait_in = 1'b1;
            end else begin
               // uncommitted byte reads as zero, position holds
               rd_byte_in = '0;
               und_in     = 1'b1;
            end
         end
      end
   end

   assign sts.busy     = busy_ff;
   assign sts.done     = done_ff;
   assign sts.underrun = und_ff;
   assign result       = res_ff;

   a_pos_behind_writer: assert property (@(posedge clock) disable iff (reset)
      rd_pos_ff <= wr_count)
      else $error("read position passed the committed bytes");

   a_wait_follows_read: assert property (@(posedge clock) disable iff (reset)
      ram_re |=> wait_ff && busy_ff)
      else $error("store read issued without a capture cycle");

endmodule

// ===== rtl/lsb_first_bit_fifo_top.sv =====
`timescale 1ns / 1ps
// LSB-first bitstream store: a 4096-byte memory filled and drained as a bitstream.
// req_ch carries a command word (cmd, value, bit_count); rsp_ch returns one word per
// command (read_value, status, bytes_stored). Both use valid/ready; a word moves when
// both are high.
// Commands run one at a time, one bit per cycle while no store byte is being fetched:
//   add bits           : shifts value into the partial byte, commits full bytes;
//   get bits           : takes bits from the current byte, fetching a new one from
//                        the store when it is used up (an underrun reads zero);
//   add byte           : flushes a partial byte first, then commits the byte;
//   pad: flushes a partial byte; get byte: fetches a new byte unless the current
//   one is untouched; unknown command: answered without running a unit.
// The bit count is saturated at 32. The next command is taken in the cycle rsp valid
// rises.
// req_ch.ready is high while no command is in progress. A finished response sits in
// an output register, so a new command is taken while rsp_ch is stalled; a second
// response then waits inside the block until the output register frees up.
// Reset (synchronous, active high) empties the store: counts, partial byte and read
// position clear. No clearing pass runs; store entries are only read once committed.
// Overflowing commits are dropped; fetches of uncommitted bytes read zero (underrun).

module lsb_first_bit_fifo_top (
   input  logic      clock,
   input  logic      reset,
   lbf_req_if.sink   req_ch,
   lbf_rsp_if.source rsp_ch
);
   import lbf_pkg::*;

   state_type         state_ff, state_in;
   logic [2:0]        cmd_ff, cmd_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] read_value_ff, read_value_in;
   logic [1:0]        status_ff, status_in;
   logic [CNT_W-1:0]  bytes_ff, bytes_in;

   ctl_type           ctl;
   wsts_type          wr_sts;
   rsts_type          rd_sts;
   logic [CNT_W-1:0]  wr_count;
   logic [DATA_W-1:0] rd_result;
   logic              accept;
   logic              out_free;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [7:0]        ram_wdata;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_raddr;
   logic [7:0]        ram_rdata;

   lbf_packer u_packer (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .sts       (wr_sts),
      .wr_count  (wr_count),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata)
   );

   lbf_unpacker u_unpacker (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .wr_count  (wr_count),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .sts       (rd_sts),
      .result    (rd_result)
   );

   lbf_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      read_value_ff <= read_value_in;
      status_ff     <= status_in;
      bytes_ff      <= bytes_in;
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      read_value_in = read_value_ff;
      status_in     = status_ff;
      bytes_in      = bytes_ff;

      ctl.start_wr = 1'b0;
      ctl.start_rd = 1'b0;
      ctl.cmd      = req_ch.cmd;
      ctl.value    = req_ch.value;
      ctl.count    = (req_ch.bit_count > MAX_BITS) ? MAX_BITS : req_ch.bit_count;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in = req_ch.cmd;
               if (is_write_cmd(req_ch.cmd)) begin
                  ctl.start_wr = 1'b1;
                  state_in     = S_BUSY;
               end else if (is_read_cmd(req_ch.cmd)) begin
                  ctl.start_rd = 1'b1;
                  state_in     = S_BUSY;
               end else begin
                  state_in = S_HOLD;
               end
            end
         end
         S_BUSY: begin
            if (wr_sts.done || rd_sts.done) begin
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               read_value_in = '0;
               status_in     = STS_OK;
               bytes_in      = wr_count;
               if (is_write_cmd(cmd_ff)) begin
                  if (wr_sts.overflow) begin
                     status_in = STS_OVERFLOW;
                  end
               end else if (is_read_cmd(cmd_ff)) begin
                  read_value_in = rd_result;
                  if (rd_sts.underrun) begin
                     status_in = STS_UNDERRUN;
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.read_value   = read_value_ff;
   assign rsp_ch.status       = status_ff;
   assign rsp_ch.bytes_stored = bytes_ff;

   a_idle_units_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !wr_sts.busy && !rd_sts.busy)
      else $error("unit still busy while commands are being taken");

   a_hold_loads_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HOLD) && out_free |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("finished response not moved to the output register");

endmodule
